// ----- rtl/core/dms_pkg.sv -----
package dms_pkg;

	// sample and geometry widths
	localparam int unsigned PIX_W     = 8;
	localparam int unsigned POS_W     = 12;
	localparam int unsigned DIM_W     = 13;
	localparam int unsigned MAX_WIDTH = 4096;
	localparam int unsigned LS_AW     = $clog2(MAX_WIDTH);

	// limits applied to the size registers
	localparam logic [DIM_W-1:0] DIM_MIN    = DIM_W'(4);
	localparam logic [DIM_W-1:0] WIDTH_MAX  = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] HEIGHT_MAX = DIM_W'(4096);

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ORDER = 2'd2;

	// reset values of the registers
	localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
	localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);

	// channel order codes
	localparam logic ORDER_BGR = 1'b0;
	localparam logic ORDER_RGB = 1'b1;

	// per-item control carried from the counter stage to the window stage
	typedef struct packed {
		logic             valid;
		logic             emit;
		logic             first_row;
		logic             frame_end;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic [PIX_W-1:0] sample;
	} stage_ctl_t;

	// one finished color pixel
	typedef struct packed {
		logic [PIX_W-1:0] first;
		logic [PIX_W-1:0] middle;
		logic [PIX_W-1:0] last;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             frame_end;
	} pixel_t;

endpackage

// ----- rtl/core/bayer_grbg_nearest_demosaic_unit.sv -----
// channel  | valid / flow       | payload
// ---------+--------------------+-------------------------------------------------
// input    | in_valid, in_stall | raw_sample
// output   | out_valid,out_stall| channel_first/middle/last, out_row, out_col,
//          |                    | frame_end
// config   | cfg_write          | cfg_index, cfg_data
//
// one item per cycle sustained while in_stall is low; a pixel leaves by way of the
// line store read and stage 1 control registers, then window and color select,
// then the output queue.
// reset clears counters, window and queue; the line store holds no reset and
// its read is replaced by zero on the first line of a frame.
// a stalled output fills a three-slot queue; input stall rises only when the
// queue and the item in flight would leave no free slot.
module bayer_grbg_nearest_demosaic_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [dms_pkg::PIX_W-1:0]         raw_sample,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [dms_pkg::PIX_W-1:0]         channel_first,
	output logic [dms_pkg::PIX_W-1:0]         channel_middle,
	output logic [dms_pkg::PIX_W-1:0]         channel_last,
	output logic [dms_pkg::POS_W-1:0]         out_row,
	output logic [dms_pkg::POS_W-1:0]         out_col,
	output logic                              frame_end,
	input  logic                              cfg_write,
	input  logic [dms_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dms_pkg::DIM_W-1:0]         cfg_data
);

	logic [dms_pkg::DIM_W-1:0] width_q, height_q;
	logic                      order_q;
	logic [dms_pkg::POS_W-1:0] col_q, row_q;
	logic [dms_pkg::DIM_W-1:0] w_eff, h_eff, x13, y13;
	logic                      accept, emit, col_wrap;
	dms_pkg::stage_ctl_t       ctl_s1;
	logic [dms_pkg::PIX_W-1:0] above_rd;
	logic                      push, pop;
	dms_pkg::pixel_t           pix, head_pix;
	logic [1:0]                q_count;
	logic [2:0]                q_load;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= dms_pkg::WIDTH_RST;
			height_q <= dms_pkg::HEIGHT_RST;
			order_q  <= dms_pkg::ORDER_BGR;
		end else if (cfg_write) begin
			unique case (cfg_index)
				dms_pkg::CFG_IMAGE_WIDTH:   width_q  <= cfg_data;
				dms_pkg::CFG_IMAGE_HEIGHT:  height_q <= cfg_data;
				dms_pkg::CFG_CHANNEL_ORDER: order_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// effective frame size
	always_comb begin
		priority if (width_q < dms_pkg::DIM_MIN) w_eff = dms_pkg::DIM_MIN;
		else if (width_q > dms_pkg::WIDTH_MAX)  w_eff = dms_pkg::WIDTH_MAX;
		else                                     w_eff = width_q;
		priority if (height_q < dms_pkg::DIM_MIN) h_eff = dms_pkg::DIM_MIN;
		else if (height_q > dms_pkg::HEIGHT_MAX) h_eff = dms_pkg::HEIGHT_MAX;
		else                                      h_eff = height_q;
	end

	// input flow: room for the item in flight and one more
	assign q_load   = {1'b0, q_count} + {2'b00, ctl_s1.valid};
	assign in_stall = (q_load >= 3'd3);
	assign accept   = in_valid & ~in_stall;

	assign x13      = {1'b0, col_q};
	assign y13      = {1'b0, row_q};
	assign col_wrap = (x13 >= w_eff - 13'd1);
	assign emit     = (row_q != '0) && (y13 <= h_eff - 13'd2) &&
	                  (x13 >= 13'd2) && (x13 <= w_eff - 13'd1);

	// raster position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= (y13 >= h_eff - 13'd1) ? '0 : row_q + 12'd1;
			end else begin
				col_q <= col_q + 12'd1;
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= accept;
			if (accept) begin
				ctl_s1.emit      <= emit;
				ctl_s1.first_row <= (row_q == '0);
				ctl_s1.frame_end <= (y13 == h_eff - 13'd2) && (x13 == w_eff - 13'd1);
				ctl_s1.row       <= row_q - 12'd1;
				ctl_s1.col       <= col_q - 12'd2;
				ctl_s1.sample    <= raw_sample;
			end
		end
	end

	// previous line store: read old entry and overwrite in one access
	dms_ram #(
		.WIDTH(dms_pkg::PIX_W),
		.DEPTH(dms_pkg::MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q[dms_pkg::LS_AW-1:0]),
		.wdata (raw_sample),
		.raddr (col_q[dms_pkg::LS_AW-1:0]),
		.rdata (above_rd)
	);

	dms_pixsel u_pixsel (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s1   (ctl_s1),
		.above_rd (above_rd),
		.order    (order_q),
		.push     (push),
		.pix      (pix)
	);

	assign pop = out_valid & ~out_stall;

	dms_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_pix (pix),
		.pop      (pop),
		.count    (q_count),
		.head_pix (head_pix)
	);

	// output item
	assign out_valid      = (q_count != 2'd0);
	assign channel_first  = head_pix.first;
	assign channel_middle = head_pix.middle;
	assign channel_last   = head_pix.last;
	assign out_row        = head_pix.row;
	assign out_col        = head_pix.col;
	assign frame_end      = head_pix.frame_end;

endmodule

// ----- rtl/core/dms_ram.sv -----
module dms_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// registered read returns the old entry on a same-address write
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

endmodule

// ----- rtl/core/dms_pixsel.sv -----
module dms_pixsel (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dms_pkg::stage_ctl_t      ctl_s1,
	input  logic [dms_pkg::PIX_W-1:0] above_rd,
	input  logic                     order,
	output logic                     push,
	output dms_pkg::pixel_t          pix
);

	// two newest samples of the previous line and of the current line
	logic [dms_pkg::PIX_W-1:0] prev0_q, prev1_q, cur0_q, cur1_q;
	logic [dms_pkg::PIX_W-1:0] above;
	logic [dms_pkg::PIX_W-1:0] red, green, blue;

	// first line of a frame sees zero above
	assign above = ctl_s1.first_row ? '0 : above_rd;

	// window shift, one column per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev0_q <= '0;
			prev1_q <= '0;
			cur0_q  <= '0;
			cur1_q  <= '0;
		end else if (ctl_s1.valid) begin
			prev0_q <= prev1_q;
			prev1_q <= above;
			cur0_q  <= cur1_q;
			cur1_q  <= ctl_s1.sample;
		end
	end

	// site selection by row and column parity
	always_comb begin
		unique case ({ctl_s1.row[0], ctl_s1.col[0]})
			2'b00: begin
				blue = cur0_q; green = prev0_q; red = prev1_q;
			end
			2'b01: begin
				blue = cur1_q; green = prev1_q; red = prev0_q;
			end
			2'b10: begin
				blue = prev0_q; green = prev1_q; red = cur1_q;
			end
			default: begin
				blue = prev1_q; green = prev0_q; red = cur0_q;
			end
		endcase
	end

	assign push          = ctl_s1.valid & ctl_s1.emit;
	assign pix.first     = (order == dms_pkg::ORDER_RGB) ? red : blue;
	assign pix.middle    = green;
	assign pix.last      = (order == dms_pkg::ORDER_RGB) ? blue : red;
	assign pix.row       = ctl_s1.row;
	assign pix.col       = ctl_s1.col;
	assign pix.frame_end = ctl_s1.frame_end;

endmodule

// ----- rtl/core/dms_outq.sv -----
module dms_outq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dms_pkg::pixel_t push_pix,
	input  logic            pop,
	output logic [1:0]      count,
	output dms_pkg::pixel_t head_pix
);

	localparam logic [1:0] LAST_SLOT = 2'd2;

	dms_pkg::pixel_t slot_q [3];
	logic [1:0] head_q, tail_q, count_q;

	// slot storage, written at the tail
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[tail_q] <= push_pix;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= (tail_q == LAST_SLOT) ? 2'd0 : tail_q + 2'd1;
			end
			if (pop) begin
				head_q <= (head_q == LAST_SLOT) ? 2'd0 : head_q + 2'd1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign count    = count_q;
	assign head_pix = slot_q[head_q];

endmodule
